FILE: hdl/assert_macros.svh
// Assertion macros shared by the burst splitter RTL.
// Included by the controller and the datapath; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ABS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define ABS_ASSERT_ONEHOT(lbl, clk, rstn, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) $onehot(sig)) \
    else $error("one-hot check failed");
`else
`define ABS_ASSERT(lbl, clk, rstn, prop)
`define ABS_ASSERT_ONEHOT(lbl, clk, rstn, sig)
`endif
`endif

FILE: hdl/abs_pkg.sv
// Package of the burst splitter: constants, codes, control structs, helpers.
// Used by abs_ctrl, abs_dp and the top level.
`default_nettype none
package abs_pkg;
  localparam int MAX_ID_BITS_DEF  = 4;
  localparam int MAX_PACKET_BYTES = 64;
  localparam int MAX_DATA_BYTES   = 64;
  localparam int DL_MAX           = $clog2(MAX_DATA_BYTES + 1) - 1;
  localparam int NUM_SRC          = 3;

  localparam logic       CMD_SPLIT   = 1'b0;
  localparam logic       CMD_RELEASE = 1'b1;
  localparam logic [1:0] SRC_HOST    = 2'd0;
  localparam logic [1:0] SRC_GPU     = 2'd1;
  localparam logic [1:0] SRC_NONE    = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED  = 2'd1;
  localparam logic [1:0] ST_DOUBLE_REL = 2'd2;

  localparam logic [2:0] REG_MONITOR_ENABLE = 3'd0;
  localparam logic [2:0] REG_SOURCE_MASK    = 3'd1;
  localparam logic [2:0] REG_TRACE_IFETCH   = 3'd2;
  localparam logic [2:0] REG_DATA_LOG2      = 3'd3;
  localparam logic [2:0] REG_ID_BITS        = 3'd4;
  localparam logic [2:0] REG_UNIQUE_IDS     = 3'd5;

  typedef struct packed {
    logic       latch;
    logic       rel_clear;
    logic       probe_start;
    logic       probe;
    logic       plan;
    logic       beat;
    logic       stat;
    logic [1:0] stat_code;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_release;
    logic rel_ignore;
    logic rel_live;
    logic filtered;
    logic pooled;
    logic probe_free;
    logic probe_last;
    logic out_free;
    logic burst_end;
    logic req_end;
  } ctl_sts_t;

  function automatic logic [2:0] flog2_7(input logic [6:0] v);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if (v[i]) r = 3'(i);
    end
    return r;
  endfunction

  function automatic logic [2:0] ctz6(input logic [5:0] a);
    logic [2:0] r;
    r = 3'd6;
    for (int i = 5; i >= 0; i--) begin
      if (a[i]) r = 3'(i);
    end
    return r;
  endfunction
endpackage
`default_nettype wire

FILE: hdl/abs_ctrl.sv
// Controller state machine of the burst splitter.
// Depends on abs_pkg and assert_macros.svh; drives the datapath abs_dp.
`default_nettype none
`include "assert_macros.svh"
module abs_ctrl
  import abs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire ctl_sts_t sts,
  output ctl_cmd_t      cmd
);
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECIDE = 6'b000010,
    S_ALLOC  = 6'b000100,
    S_PLAN   = 6'b001000,
    S_BEAT   = 6'b010000,
    S_STAT   = 6'b100000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] code_r, code_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    code_nxt      = code_r;
    cmd           = '0;
    cmd.stat_code = code_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.is_release) begin
          if (sts.rel_ignore) begin
            state_nxt = S_IDLE;
          end else if (sts.rel_live) begin
            cmd.rel_clear = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            code_nxt  = ST_DOUBLE_REL;
            state_nxt = S_STAT;
          end
        end else if (sts.filtered) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.probe_start = 1'b1;
          state_nxt       = sts.pooled ? S_ALLOC : S_PLAN;
        end
      end
      S_ALLOC: begin
        cmd.probe = 1'b1;
        if (sts.probe_free) begin
          state_nxt = S_PLAN;
        end else if (sts.probe_last) begin
          code_nxt  = ST_EXHAUSTED;
          state_nxt = S_STAT;
        end
      end
      S_PLAN: begin
        cmd.plan  = 1'b1;
        state_nxt = S_BEAT;
      end
      S_BEAT: begin
        if (sts.out_free) begin
          cmd.beat = 1'b1;
          if (sts.req_end) begin
            state_nxt = S_IDLE;
          end else if (sts.burst_end) begin
            state_nxt = S_PLAN;
          end
        end
      end
      S_STAT: begin
        if (sts.out_free) begin
          cmd.stat  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= ST_OK;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  `ABS_ASSERT(a_emit_needs_room, clk, rst_n, (cmd.beat || cmd.stat) |-> sts.out_free)
  `ABS_ASSERT(a_probe_only_pooled, clk, rst_n, cmd.probe |-> sts.pooled)
  `ABS_ASSERT(a_req_end_idle, clk, rst_n, (cmd.beat && sts.req_end) |=> state_r == S_IDLE)
  `ABS_ASSERT_ONEHOT(a_state_onehot, clk, rst_n, state_r)
endmodule
`default_nettype wire

FILE: hdl/abs_dp.sv
// Datapath of the burst splitter: configuration, id pool, burst planner, output register.
// Depends on abs_pkg and assert_macros.svh; controlled by abs_ctrl.
`default_nettype none
`include "assert_macros.svh"
module abs_dp
  import abs_pkg::*;
#(
  parameter int MAX_ID_BITS = MAX_ID_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [2:0]  cfg_data,
  input  wire logic        in_cmd,
  input  wire logic [1:0]  in_source,
  input  wire logic [15:0] in_requester,
  input  wire logic        in_has_stream_id,
  input  wire logic [31:0] in_stream_id,
  input  wire logic        in_is_write,
  input  wire logic        in_is_inst_fetch,
  input  wire logic        in_is_prefetch,
  input  wire logic [63:0] in_address,
  input  wire logic [6:0]  in_size,
  input  wire logic [63:0] in_byte_mask,
  input  wire logic [3:0]  in_release_id,
  input  wire ctl_cmd_t    cmd,
  output ctl_sts_t         sts,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_burst_address,
  output logic [6:0]       out_burst_beats,
  output logic [2:0]       out_beat_size_log2,
  output logic [3:0]       out_axi_id,
  output logic [31:0]      out_context_id,
  output logic [1:0]       out_user_source,
  output logic [2:0]       out_flags,
  output logic [63:0]      out_strobe_res,
  output logic             out_burst_last,
  output logic             out_last,
  output logic [1:0]       out_status
);
  localparam int POOL  = 1 << MAX_ID_BITS;
  localparam int IDC_W = MAX_ID_BITS + 1;

  logic       mon_en_r, tif_r, unique_r;
  logic [2:0] src_mask_r, dlog2_r, id_bits_r;

  logic        req_cmd_r, has_r, wr_r, ifetch_r, pref_r;
  logic [1:0]  src_r;
  logic [15:0] requestor_r;
  logic [31:0] stream_r;
  logic [63:0] be_r;
  logic [3:0]  rel_r;
  logic [63:0] cur_addr_r, burst_addr_r;
  logic [6:0]  rem_r, offset_r, beats_r, beat_cnt_r;
  logic [2:0]  blog_r;
  logic [3:0]  axi_id_r;

  logic [POOL-1:0]        live_r [NUM_SRC];
  logic [MAX_ID_BITS-1:0] next_id_r [NUM_SRC];
  logic [MAX_ID_BITS-1:0] probe_cnt_r;

  logic                   out_valid_r, out_valid_nxt;
  logic [63:0]            o_addr_r, o_strobe_r;
  logic [6:0]             o_beats_r;
  logic [2:0]             o_blog_r, o_flags_r;
  logic [3:0]             o_id_r;
  logic [31:0]            o_ctx_r;
  logic [1:0]             o_src_r, o_status_r;
  logic                   o_blast_r, o_last_r;

  logic [4:0]             ib;
  logic [IDC_W-1:0]       id_cnt;
  logic [MAX_ID_BITS-1:0] id_mask, cand, rel_idx;
  logic [2:0]             dl, blog_c;
  logic                   src_ok, rel_in;
  logic [1:0]             src_idx;
  logic [31:0]            stream_sel, ctx;
  logic [2:0]             flags;
  logic [12:0]            to4k, bt1, bt2;
  logic [6:0]             bb;
  logic [5:0]             dmask, lane_base;
  logic [63:0]            lane_mask, strobe;

  always_comb begin
    ib = 5'(id_bits_r);
    if (id_bits_r == 3'd0) ib = 5'd1;
    if (5'(id_bits_r) > 5'(MAX_ID_BITS)) ib = 5'(MAX_ID_BITS);
    id_cnt  = IDC_W'(1) << ib;
    id_mask = MAX_ID_BITS'(id_cnt - IDC_W'(1));
    dl = dlog2_r;
    if (dl > 3'(DL_MAX)) dl = 3'(DL_MAX);
    src_ok  = (src_r != SRC_NONE);
    src_idx = src_ok ? src_r : SRC_HOST;
    rel_in  = (32'(rel_r) < POOL);
    rel_idx = MAX_ID_BITS'(rel_r);
    cand    = next_id_r[src_idx] & id_mask;
    stream_sel = has_r ? stream_r : {16'd0, requestor_r};
    ctx     = (src_r == SRC_HOST) ? {16'd0, requestor_r} : stream_sel;
    flags   = {(src_r == SRC_GPU) && !has_r, pref_r, ifetch_r};

    blog_c = flog2_7(rem_r);
    if (dl < blog_c) blog_c = dl;
    if (ctz6(cur_addr_r[5:0]) < blog_c) blog_c = ctz6(cur_addr_r[5:0]);
    to4k = 13'd4096 - {1'b0, cur_addr_r[11:0]};
    bt1  = 13'(rem_r) >> blog_c;
    bt2  = to4k >> blog_c;

    bb        = 7'd1 << blog_r;
    dmask     = 6'((7'd1 << dl) - 7'd1);
    lane_base = cur_addr_r[5:0] & dmask;
    lane_mask = (blog_r == 3'd6) ? '1 : ((64'd1 << bb) - 64'd1);
    strobe    = wr_r ? (((be_r >> offset_r[5:0]) & lane_mask) << lane_base) : '0;

    sts.is_release = (req_cmd_r == CMD_RELEASE);
    sts.rel_ignore = !unique_r || !src_ok;
    sts.rel_live   = rel_in && live_r[src_idx][rel_idx];
    sts.filtered   = !mon_en_r || (rem_r == 7'd0) || !src_ok || (ifetch_r && !tif_r) ||
                     !src_mask_r[src_idx];
    sts.pooled     = unique_r;
    sts.probe_free = !live_r[src_idx][cand];
    sts.probe_last = (probe_cnt_r == id_mask);
    sts.out_free   = !out_valid_r || !out_stall;
    sts.burst_end  = (beat_cnt_r + 7'd1 == beats_r);
    sts.req_end    = (rem_r == bb);

    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.beat || cmd.stat) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mon_en_r   <= 1'b0;
      src_mask_r <= 3'd0;
      tif_r      <= 1'b0;
      dlog2_r    <= 3'd3;
      id_bits_r  <= 3'd4;
      unique_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MONITOR_ENABLE: mon_en_r   <= cfg_data[0];
        REG_SOURCE_MASK:    src_mask_r <= cfg_data;
        REG_TRACE_IFETCH:   tif_r      <= cfg_data[0];
        REG_DATA_LOG2:      dlog2_r    <= cfg_data;
        REG_ID_BITS:        id_bits_r  <= cfg_data;
        REG_UNIQUE_IDS:     unique_r   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SRC; s++) begin
        live_r[s]    <= '0;
        next_id_r[s] <= '0;
      end
    end else if (cmd.rel_clear) begin
      live_r[src_idx][rel_idx] <= 1'b0;
    end else if (cmd.probe) begin
      next_id_r[src_idx] <= (cand + MAX_ID_BITS'(1)) & id_mask;
      if (!live_r[src_idx][cand]) live_r[src_idx][cand] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_cmd_r   <= in_cmd;
      src_r       <= in_source;
      requestor_r <= in_requester;
      has_r       <= in_has_stream_id;
      stream_r    <= in_stream_id;
      wr_r        <= in_is_write;
      ifetch_r    <= in_is_inst_fetch;
      pref_r      <= in_is_prefetch;
      be_r        <= in_byte_mask;
      rel_r       <= in_release_id;
      cur_addr_r  <= in_address;
      rem_r       <= (32'(in_size) > MAX_PACKET_BYTES) ? 7'(MAX_PACKET_BYTES) : in_size;
      offset_r    <= 7'd0;
    end
    if (cmd.probe_start) begin
      axi_id_r    <= 4'(MAX_ID_BITS'(stream_sel) & id_mask);
      probe_cnt_r <= '0;
    end
    if (cmd.probe) begin
      probe_cnt_r <= probe_cnt_r + MAX_ID_BITS'(1);
      if (!live_r[src_idx][cand]) axi_id_r <= 4'(cand);
    end
    if (cmd.plan) begin
      blog_r       <= blog_c;
      beats_r      <= 7'((bt1 < bt2) ? bt1 : bt2);
      burst_addr_r <= cur_addr_r;
      beat_cnt_r   <= 7'd0;
    end
    if (cmd.beat) begin
      cur_addr_r <= cur_addr_r + 64'(bb);
      rem_r      <= rem_r - bb;
      offset_r   <= offset_r + bb;
      beat_cnt_r <= beat_cnt_r + 7'd1;
      o_addr_r   <= burst_addr_r;
      o_beats_r  <= beats_r;
      o_blog_r   <= blog_r;
      o_id_r     <= axi_id_r;
      o_ctx_r    <= ctx;
      o_src_r    <= src_r;
      o_flags_r  <= flags;
      o_strobe_r <= strobe;
      o_blast_r  <= sts.burst_end;
      o_last_r   <= sts.req_end;
      o_status_r <= ST_OK;
    end
    if (cmd.stat) begin
      o_addr_r   <= '0;
      o_beats_r  <= '0;
      o_blog_r   <= '0;
      o_id_r     <= '0;
      o_ctx_r    <= '0;
      o_src_r    <= '0;
      o_flags_r  <= '0;
      o_strobe_r <= '0;
      o_blast_r  <= 1'b0;
      o_last_r   <= 1'b1;
      o_status_r <= cmd.stat_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_burst_address  = o_addr_r;
  assign out_burst_beats    = o_beats_r;
  assign out_beat_size_log2 = o_blog_r;
  assign out_axi_id         = o_id_r;
  assign out_context_id     = o_ctx_r;
  assign out_user_source    = o_src_r;
  assign out_flags          = o_flags_r;
  assign out_strobe_res     = o_strobe_r;
  assign out_burst_last     = o_blast_r;
  assign out_last           = o_last_r;
  assign out_status         = o_status_r;

  `ABS_ASSERT(a_beat_has_bytes, clk, rst_n, cmd.beat |-> rem_r != 7'd0)
  `ABS_ASSERT(a_plan_nonempty, clk, rst_n, cmd.plan |-> ((bt1 < bt2) ? bt1 : bt2) != 13'd0)
endmodule
`default_nettype wire

FILE: hdl/axi_burst_splitter_with_id_pool_core.sv
// Top level of the AXI INCR burst splitter with per-source id pool.
// Instantiates abs_ctrl and abs_dp; depends on abs_pkg.
//
// One request is taken at a time. A split request is accepted, then decided;
// when pooled ids are on it searches the id pool for a free id, and it is then
// planned once per burst and emitted beat by beat, each beat waiting for room
// in the output register. The beats are set by the bus width, the address
// alignment and the bytes left, and the pool search probes one entry per cycle
// from the rotating pointer. Results leave through an output register, so the
// next request is accepted while the final result waits.
`default_nettype none
module axi_burst_splitter_with_id_pool_core
  import abs_pkg::*;
#(
  parameter int MAX_ID_BITS = MAX_ID_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [2:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_cmd,
  input  wire logic [1:0]  in_source,
  input  wire logic [15:0] in_requester,
  input  wire logic        in_has_stream_id,
  input  wire logic [31:0] in_stream_id,
  input  wire logic        in_is_write,
  input  wire logic        in_is_inst_fetch,
  input  wire logic        in_is_prefetch,
  input  wire logic [63:0] in_address,
  input  wire logic [6:0]  in_size,
  input  wire logic [63:0] in_byte_mask,
  input  wire logic [3:0]  in_release_id,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_burst_address,
  output logic [6:0]       out_burst_beats,
  output logic [2:0]       out_beat_size_log2,
  output logic [3:0]       out_axi_id,
  output logic [31:0]      out_context_id,
  output logic [1:0]       out_user_source,
  output logic [2:0]       out_flags,
  output logic [63:0]      out_strobe_res,
  output logic             out_burst_last,
  output logic             out_last,
  output logic [1:0]       out_status
);
  ctl_cmd_t cmd;
  ctl_sts_t sts;

  abs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  abs_dp #(
    .MAX_ID_BITS (MAX_ID_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_cmd             (in_cmd),
    .in_source          (in_source),
    .in_requester       (in_requester),
    .in_has_stream_id   (in_has_stream_id),
    .in_stream_id       (in_stream_id),
    .in_is_write        (in_is_write),
    .in_is_inst_fetch   (in_is_inst_fetch),
    .in_is_prefetch     (in_is_prefetch),
    .in_address         (in_address),
    .in_size            (in_size),
    .in_byte_mask       (in_byte_mask),
    .in_release_id      (in_release_id),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_burst_address  (out_burst_address),
    .out_burst_beats    (out_burst_beats),
    .out_beat_size_log2 (out_beat_size_log2),
    .out_axi_id         (out_axi_id),
    .out_context_id     (out_context_id),
    .out_user_source    (out_user_source),
    .out_flags          (out_flags),
    .out_strobe_res     (out_strobe_res),
    .out_burst_last     (out_burst_last),
    .out_last           (out_last),
    .out_status         (out_status)
  );
endmodule
`default_nettype wire
